>>> hdl/irpde_pkg.sv
`default_nettype none

package irpde_pkg;

    // register defaults
    localparam logic [7:0] PREAMBLE_MARK_RESET  = 8'd42;
    localparam logic [7:0] PREAMBLE_SPACE_RESET = 8'd20;
    localparam logic [5:0] ONE_EXTRA_RESET      = 6'd6;

    // configuration register indexes
    localparam logic [1:0] REG_PREAMBLE_MARK  = 2'd0;
    localparam logic [1:0] REG_PREAMBLE_SPACE = 2'd1;
    localparam logic [1:0] REG_ONE_EXTRA      = 2'd2;

    // segment positions within one byte's run
    localparam logic [5:0] POS_PREAMBLE_MARK  = 6'd0;
    localparam logic [5:0] POS_PREAMBLE_SPACE = 6'd1;
    localparam logic [5:0] POS_FIRST_BIT      = 6'd2;
    localparam logic [5:0] POS_LAST_BIT_SEG   = 6'd33;
    localparam logic [5:0] POS_TRAILER_START  = 6'd34;
    localparam logic [5:0] POS_TRAILER_END    = 6'd37;

    // segments inside one bit cell (and the trailer)
    localparam logic [1:0] CELL_MARK_LONG  = 2'd0;
    localparam logic [1:0] CELL_SPACE_ONE  = 2'd1;
    localparam logic [1:0] CELL_MARK_ONE   = 2'd2;
    localparam logic [1:0] CELL_SPACE_TAIL = 2'd3;

    typedef struct packed {
        logic       carrier_on;
        logic [7:0] duration_words;
        logic       run_last;
        logic       message_end;
    } t_seg;

    typedef struct packed {
        logic [7:0] preamble_mark_len;
        logic [7:0] preamble_space_len;
        logic [5:0] one_extra_space;
    } t_cfg;

endpackage

`default_nettype wire

>>> hdl/irpde_seg_gen.sv
`default_nettype none

// Decodes a segment position into level and length.
module irpde_seg_gen (
    input  wire logic [5:0]      i_pos,
    input  wire logic [7:0]      i_data_byte,
    input  wire logic            i_last_byte,
    input  wire irpde_pkg::t_cfg i_cfg,
    output irpde_pkg::t_seg      o_seg
);
    import irpde_pkg::*;

    logic [4:0] pos_rel;
    logic [2:0] bit_num;
    logic [1:0] slot;
    logic       bit_val;
    logic       in_trailer;
    logic [7:0] tail_len;

    // offset from the first bit cell: bit number and slot within the cell
    assign pos_rel    = 5'(i_pos - POS_FIRST_BIT);
    assign bit_num    = pos_rel[4:2];
    assign slot       = pos_rel[1:0];
    assign in_trailer = (i_pos >= POS_TRAILER_START);
    assign bit_val    = i_data_byte[3'd7 - bit_num];
    assign tail_len   = (bit_val && !in_trailer) ? (8'd2 + {2'b00, i_cfg.one_extra_space})
                                                 : 8'd2;

    always_comb begin
        o_seg.carrier_on     = 1'b0;
        o_seg.duration_words = 8'd1;
        if (i_pos == POS_PREAMBLE_MARK) begin
            o_seg.carrier_on     = 1'b1;
            o_seg.duration_words = (i_cfg.preamble_mark_len == 8'd0) ? 8'd1
                                                                     : i_cfg.preamble_mark_len;
        end else if (i_pos == POS_PREAMBLE_SPACE) begin
            o_seg.carrier_on     = 1'b0;
            o_seg.duration_words = (i_cfg.preamble_space_len == 8'd0) ? 8'd1
                                                                      : i_cfg.preamble_space_len;
        end else begin
            unique case (slot)
                CELL_MARK_LONG: begin
                    o_seg.carrier_on     = 1'b1;
                    o_seg.duration_words = 8'd2;
                end
                CELL_SPACE_ONE: begin
                    o_seg.carrier_on     = 1'b0;
                    o_seg.duration_words = 8'd1;
                end
                CELL_MARK_ONE: begin
                    o_seg.carrier_on     = 1'b1;
                    o_seg.duration_words = 8'd1;
                end
                CELL_SPACE_TAIL: begin
                    o_seg.carrier_on     = 1'b0;
                    o_seg.duration_words = tail_len;
                end
                default: begin
                    o_seg.carrier_on     = 1'b0;
                    o_seg.duration_words = 8'd1;
                end
            endcase
        end
        // run ends after the last bit cell, or after the trailer
        o_seg.run_last    = i_last_byte ? (i_pos == POS_TRAILER_END)
                                        : (i_pos == POS_LAST_BIT_SEG);
        o_seg.message_end = (i_pos == POS_TRAILER_END);
    end

endmodule

`default_nettype wire

>>> hdl/ir_pulse_distance_encoder_core.sv
`default_nettype none

// IR pulse-distance encoder. Each accepted byte word becomes a run of mark/space
// segments, one segment per cycle unless the output stalls, from a segment position
// counter: 32 segments for the eight bit cells (MSB first), 2 more when tuser (first
// byte) brings the preamble, 4 more when tlast (last byte) brings the trailer, so 32
// to 38 segments per byte. The next byte is taken in the cycle the current run's final
// segment moves into the output register, so runs follow each other without a gap.
// Output tlast marks the end of each byte's run, output tuser the final trailer
// segment of a message. Configuration writes take effect at once and are meant
// for idle periods; a preamble length written as 0 is sent as 1 word.
module ir_pulse_distance_encoder_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration write port
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [7:0]  i_cfg_data,
    // byte input
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic        s_axis_tuser,   // [0] first_byte
    input  wire logic        s_axis_tlast,   // last_byte
    // segment output
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [0] carrier_on, [8:1] duration_words, pad
    output logic             m_axis_tuser,   // [0] message_end
    output logic             m_axis_tlast    // run_last
);
    import irpde_pkg::*;

    t_cfg       r_cfg;
    logic       r_busy;
    logic [5:0] r_pos;
    logic [7:0] r_byte;
    logic       r_last;
    logic       r_out_valid;
    t_seg       r_out;

    t_seg       seg;
    logic       advance;
    logic       accept;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.preamble_mark_len  <= PREAMBLE_MARK_RESET;
            r_cfg.preamble_space_len <= PREAMBLE_SPACE_RESET;
            r_cfg.one_extra_space    <= ONE_EXTRA_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_PREAMBLE_MARK:  r_cfg.preamble_mark_len  <= i_cfg_data;
                REG_PREAMBLE_SPACE: r_cfg.preamble_space_len <= i_cfg_data;
                REG_ONE_EXTRA:      r_cfg.one_extra_space    <= i_cfg_data[5:0];
                default: ;
            endcase
        end
    end

    // segment decode for the current position
    irpde_seg_gen u_seg_gen (
        .i_pos       (r_pos),
        .i_data_byte (r_byte),
        .i_last_byte (r_last),
        .i_cfg       (r_cfg),
        .o_seg       (seg)
    );

    // issue one segment whenever the output register is free or draining
    assign advance       = r_busy && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_busy || (advance && seg.run_last);
    assign accept        = s_axis_tvalid && s_axis_tready;

    // input word and position counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pos  <= POS_FIRST_BIT;
        end else if (accept) begin
            r_busy <= 1'b1;
            r_pos  <= s_axis_tuser ? POS_PREAMBLE_MARK : POS_FIRST_BIT;
        end else if (advance) begin
            if (seg.run_last) begin
                r_busy <= 1'b0;
            end
            r_pos <= r_pos + 6'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_byte <= s_axis_tdata;
            r_last <= s_axis_tlast;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= seg;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out.duration_words, r_out.carrier_on};
    assign m_axis_tuser  = r_out.message_end;
    assign m_axis_tlast  = r_out.run_last;

endmodule

`default_nettype wire

>>> tb/ir_segment_checker.sv
`timescale 1ns / 100ps

module ir_segment_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // register writes
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [7:0]  i_cfg_data,
    // byte channel
    input  wire logic        i_byte_valid,
    input  wire logic        i_byte_ready,
    input  wire logic [7:0]  i_byte_data,
    input  wire logic        i_byte_first,
    input  wire logic        i_byte_last,
    // segment channel
    input  wire logic        i_seg_valid,
    input  wire logic        i_seg_ready,
    input  wire logic [15:0] i_seg_data,    // [0] carrier_on, [8:1] duration_words, pad
    input  wire logic        i_seg_msg_end,
    input  wire logic        i_seg_run_last,
    // status for the test top
    output int               o_errors,
    output int               o_pending,
    output int               o_bytes,
    output int               o_segments
);
    import irpde_pkg::*;

    t_seg segs_due[$];
    t_cfg cfg_shadow;
    int   err_count;
    int   byte_count;
    int   seg_count;
    int   pending;
    t_seg seg_got;
    t_seg seg_want;

    assign o_errors   = err_count;
    assign o_pending  = pending;
    assign o_bytes    = byte_count;
    assign o_segments = seg_count;

    initial begin
        err_count  = 0;
        byte_count = 0;
        seg_count  = 0;
        pending    = 0;
    end

    function automatic void queue_segment(logic on, logic [7:0] len);
        t_seg s;
        s.carrier_on     = on;
        s.duration_words = len;
        s.run_last       = 1'b0;
        s.message_end    = 1'b0;
        segs_due.push_back(s);
    endfunction

    // a zero-length preamble register still yields a one-word segment
    function automatic logic [7:0] min_one(logic [7:0] v);
        return (v == 8'd0) ? 8'd1 : v;
    endfunction

    // expected segment run for one accepted byte
    function automatic void predict_byte_segments(logic [7:0] data, logic first, logic last);
        logic [7:0] tail;
        t_seg       closing;
        if (first) begin
            queue_segment(1'b1, min_one(cfg_shadow.preamble_mark_len));
            queue_segment(1'b0, min_one(cfg_shadow.preamble_space_len));
        end
        for (int b = 7; b >= 0; b--) begin
            tail = data[b] ? 8'd2 + 8'(cfg_shadow.one_extra_space) : 8'd2;
            queue_segment(1'b1, 8'd2);
            queue_segment(1'b0, 8'd1);
            queue_segment(1'b1, 8'd1);
            queue_segment(1'b0, tail);
        end
        // trailer has the same shape as a zero bit
        if (last) begin
            queue_segment(1'b1, 8'd2);
            queue_segment(1'b0, 8'd1);
            queue_segment(1'b1, 8'd1);
            queue_segment(1'b0, 8'd2);
        end
        closing             = segs_due.pop_back();
        closing.run_last    = 1'b1;
        closing.message_end = last;
        segs_due.push_back(closing);
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            err_count++;
            $error("%s: expected %0d, got %0d", name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_shadow.preamble_mark_len  = PREAMBLE_MARK_RESET;
            cfg_shadow.preamble_space_len = PREAMBLE_SPACE_RESET;
            cfg_shadow.one_extra_space    = ONE_EXTRA_RESET;
            segs_due.delete();
        end else begin
            // outgoing segment against the oldest expectation
            if (i_seg_valid && i_seg_ready) begin
                seg_count++;
                seg_got.carrier_on     = i_seg_data[0];
                seg_got.duration_words = i_seg_data[8:1];
                seg_got.run_last       = i_seg_run_last;
                seg_got.message_end    = i_seg_msg_end;
                if (segs_due.size() == 0) begin
                    err_count++;
                    $error("unexpected segment: carrier_on %0d duration_words %0d",
                           seg_got.carrier_on, seg_got.duration_words);
                end else begin
                    seg_want = segs_due.pop_front();
                    check_field("carrier_on", seg_want.carrier_on, seg_got.carrier_on);
                    check_field("duration_words", seg_want.duration_words,
                                seg_got.duration_words);
                    check_field("run_last", seg_want.run_last, seg_got.run_last);
                    check_field("message_end", seg_want.message_end, seg_got.message_end);
                end
            end
            // incoming byte word
            if (i_byte_valid && i_byte_ready) begin
                byte_count++;
                predict_byte_segments(i_byte_data, i_byte_first, i_byte_last);
            end
            // register shadow; unknown indexes are dropped
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_PREAMBLE_MARK:  cfg_shadow.preamble_mark_len  = i_cfg_data;
                    REG_PREAMBLE_SPACE: cfg_shadow.preamble_space_len = i_cfg_data;
                    REG_ONE_EXTRA:      cfg_shadow.one_extra_space    = i_cfg_data[5:0];
                    default: ;
                endcase
            end
        end
        pending = segs_due.size();
    end

endmodule

>>> tb/ir_pulse_distance_encoder_core_test.sv
`timescale 1ns / 100ps

module ir_pulse_distance_encoder_core_test;
    import irpde_pkg::*;

    localparam int         N_BYTES      = 430;
    localparam int         PHASE_BYTES  = 50;
    localparam int         HOLD_CYCLES  = 300;
    localparam int         STALL_LIMIT  = 3000;
    localparam int         DRAIN_CYCLES = 8;
    localparam logic [1:0] REG_UNUSED   = 2'd3;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        cfg_we       = 1'b0;
    logic [1:0]  cfg_idx      = REG_PREAMBLE_MARK;
    logic [7:0]  cfg_data     = 8'd0;
    logic        byte_valid   = 1'b0;
    logic        byte_ready;
    logic [7:0]  byte_data    = 8'd0;
    logic        byte_first   = 1'b0;
    logic        byte_last    = 1'b0;
    logic        seg_valid;
    logic        seg_ready    = 1'b0;
    logic [15:0] seg_data;
    logic        seg_msg_end;
    logic        seg_run_last;

    int errors;
    int pending;
    int bytes_seen;
    int segs_seen;

    bit busy          = 1'b0;
    int hold_requests = 0;
    int holds_done    = 0;
    int n_sent        = 0;
    int settings      = 0;
    int idle_cycles   = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    ir_pulse_distance_encoder_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .s_axis_tvalid (byte_valid),
        .s_axis_tready (byte_ready),
        .s_axis_tdata  (byte_data),     // [7:0] data_byte
        .s_axis_tuser  (byte_first),    // [0] first_byte
        .s_axis_tlast  (byte_last),
        .m_axis_tvalid (seg_valid),
        .m_axis_tready (seg_ready),
        .m_axis_tdata  (seg_data),      // [0] carrier_on, [8:1] duration_words, pad
        .m_axis_tuser  (seg_msg_end),   // [0] message_end
        .m_axis_tlast  (seg_run_last)
    );

    ir_segment_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_data     (cfg_data),
        .i_byte_valid   (byte_valid),
        .i_byte_ready   (byte_ready),
        .i_byte_data    (byte_data),
        .i_byte_first   (byte_first),
        .i_byte_last    (byte_last),
        .i_seg_valid    (seg_valid),
        .i_seg_ready    (seg_ready),
        .i_seg_data     (seg_data),
        .i_seg_msg_end  (seg_msg_end),
        .i_seg_run_last (seg_run_last),
        .o_errors       (errors),
        .o_pending      (pending),
        .o_bytes        (bytes_seen),
        .o_segments     (segs_seen)
    );

    // watchdog: too long without any word moving on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (byte_valid && byte_ready) || (seg_valid && seg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // segment sink: random stalls per word, one long hold-off on request
    initial begin : segment_sink
        int stall;
        forever begin
            if (holds_done < hold_requests) begin
                holds_done++;
                seg_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                stall = busy ? 0 : $urandom_range(0, 8);
                if (stall > 0) begin
                    seg_ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
            seg_ready <= 1'b1;
            @(posedge i_clk);
            while (!seg_valid) @(posedge i_clk);
        end
    end

    task automatic send_byte(logic [7:0] data, logic first, logic last);
        int gap;
        gap = busy ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            byte_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        byte_valid <= 1'b1;
        byte_data  <= data;
        byte_first <= first;
        byte_last  <= last;
        @(posedge i_clk);
        while (!byte_ready) @(posedge i_clk);
        n_sent++;
    endtask

    // well-formed message: preamble on the first byte, trailer on the last
    task automatic send_message(int len);
        for (int k = 0; k < len; k++) begin
            send_byte(8'($urandom_range(0, 255)), k == 0, k == len - 1);
        end
    endtask

    // stop offering and wait until every expected segment is out
    task automatic wait_drained();
        byte_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [7:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
    endtask

    task automatic apply_config(logic [7:0] mark, logic [7:0] space, logic [7:0] extra,
                                bit stray);
        write_reg(REG_PREAMBLE_MARK, mark);
        write_reg(REG_PREAMBLE_SPACE, space);
        write_reg(REG_ONE_EXTRA, extra);
        if (stray) write_reg(REG_UNUSED, 8'($urandom_range(0, 255)));
        cfg_we <= 1'b0;
        settings++;
    endtask

    function automatic logic [7:0] pick_reg_value();
        case ($urandom_range(0, 4))
            0:       return 8'd0;
            1:       return 8'd1;
            2:       return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    initial begin : stimulus
        int phase;
        int phase_start;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset defaults: all flag combinations, alternating and single-bit bytes
        send_byte(8'h00, 1'b1, 1'b1);
        send_byte(8'hFF, 1'b1, 1'b1);
        send_byte(8'h80, 1'b1, 1'b0);
        send_byte(8'h01, 1'b0, 1'b0);
        send_byte(8'hAA, 1'b0, 1'b0);
        send_byte(8'h55, 1'b0, 1'b1);
        send_byte(8'h3C, 1'b0, 1'b0);
        send_byte(8'hC3, 1'b1, 1'b1);

        // zero preamble lengths, longest space, write to an unknown index
        wait_drained();
        apply_config(8'd0, 8'd0, 8'd63, 1'b1);
        send_byte(8'hFF, 1'b1, 1'b1);
        send_byte(8'h00, 1'b1, 1'b1);
        send_byte(8'h7E, 1'b1, 1'b0);
        send_byte(8'h81, 1'b0, 1'b1);

        // longest preamble; extra-space bits above the register width dropped
        wait_drained();
        apply_config(8'd255, 8'd255, 8'hC0, 1'b0);
        send_byte(8'hFF, 1'b1, 1'b1);
        send_byte(8'hA5, 1'b1, 1'b1);
        send_byte(8'h5A, 1'b0, 1'b0);

        wait_drained();
        apply_config(8'd1, 8'd1, 8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1, 1'b1);
        send_byte(8'h0F, 1'b1, 1'b1);

        // random phases: mostly proper messages, some loose bytes with random flags
        phase = 0;
        while (n_sent < N_BYTES) begin
            wait_drained();
            apply_config(pick_reg_value(), pick_reg_value(), pick_reg_value(),
                         $urandom_range(0, 3) == 0);
            busy = (phase % 3 == 1) || (phase == 2);
            if (phase == 2) hold_requests++;
            phase_start = n_sent;
            while (n_sent - phase_start < PHASE_BYTES && n_sent < N_BYTES) begin
                if ($urandom_range(0, 99) < 85) begin
                    send_message($urandom_range(1, 6));
                end else begin
                    send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)));
                end
            end
            phase++;
        end

        wait_drained();
        busy = 1'b0;

        $display("Covered %0d bytes and %0d segments over %0d register settings,",
                 bytes_seen, segs_seen, settings);
        $display("including zero and full preamble lengths and one long output hold-off.");
        if (errors == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            if (pending != 0) $error("%0d expected segments never arrived", pending);
            $display("FAIL");
        end
        $finish;
    end

endmodule
